[sv/sha256_stream_hasher_unit_defines.svh]
// assertion macros used by the checker file
`ifndef SHA256_STREAM_HASHER_UNIT_DEFINES_SVH
`define SHA256_STREAM_HASHER_UNIT_DEFINES_SVH

// same-cycle implication, reset masked
`define SHS_CHECK_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset masked
`define SHS_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/shs_pkg.sv]
// ----------------------------------------------------------------------------
// shs_pkg
// types, constants and round functions of the sha-256 stream hasher
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package shs_pkg;

    localparam int unsigned BlockWords = 16;
    localparam int unsigned Rounds     = 64;
    localparam logic [7:0]  PadByte    = 8'h80;
    localparam logic [3:0]  LenHiWord  = 4'd14;

    // word moved from front to back through the queue
    typedef struct packed {
        logic        fin;
        logic [31:0] word;
    } t_word_item;

    typedef enum logic [2:0] {
        F_IDLE, F_PAD, F_ZERO, F_LEN_HI, F_LEN_LO
    } t_front_state;

    typedef enum logic [1:0] {
        B_COLLECT, B_ROUND, B_ADD, B_EMIT
    } t_back_state;

    typedef logic [31:0] t_chain [8];

    function automatic logic [31:0] init_h(input logic [2:0] idx);
        logic [31:0] v;
        case (idx)
            3'd0: v = 32'h6a09e667;
            3'd1: v = 32'hbb67ae85;
            3'd2: v = 32'h3c6ef372;
            3'd3: v = 32'ha54ff53a;
            3'd4: v = 32'h510e527f;
            3'd5: v = 32'h9b05688c;
            3'd6: v = 32'h1f83d9ab;
            3'd7: v = 32'h5be0cd19;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] r);
        logic [31:0] v;
        case (r)
            6'd0:  v = 32'h428a2f98; 6'd1:  v = 32'h71374491;
            6'd2:  v = 32'hb5c0fbcf; 6'd3:  v = 32'he9b5dba5;
            6'd4:  v = 32'h3956c25b; 6'd5:  v = 32'h59f111f1;
            6'd6:  v = 32'h923f82a4; 6'd7:  v = 32'hab1c5ed5;
            6'd8:  v = 32'hd807aa98; 6'd9:  v = 32'h12835b01;
            6'd10: v = 32'h243185be; 6'd11: v = 32'h550c7dc3;
            6'd12: v = 32'h72be5d74; 6'd13: v = 32'h80deb1fe;
            6'd14: v = 32'h9bdc06a7; 6'd15: v = 32'hc19bf174;
            6'd16: v = 32'he49b69c1; 6'd17: v = 32'hefbe4786;
            6'd18: v = 32'h0fc19dc6; 6'd19: v = 32'h240ca1cc;
            6'd20: v = 32'h2de92c6f; 6'd21: v = 32'h4a7484aa;
            6'd22: v = 32'h5cb0a9dc; 6'd23: v = 32'h76f988da;
            6'd24: v = 32'h983e5152; 6'd25: v = 32'ha831c66d;
            6'd26: v = 32'hb00327c8; 6'd27: v = 32'hbf597fc7;
            6'd28: v = 32'hc6e00bf3; 6'd29: v = 32'hd5a79147;
            6'd30: v = 32'h06ca6351; 6'd31: v = 32'h14292967;
            6'd32: v = 32'h27b70a85; 6'd33: v = 32'h2e1b2138;
            6'd34: v = 32'h4d2c6dfc; 6'd35: v = 32'h53380d13;
            6'd36: v = 32'h650a7354; 6'd37: v = 32'h766a0abb;
            6'd38: v = 32'h81c2c92e; 6'd39: v = 32'h92722c85;
            6'd40: v = 32'ha2bfe8a1; 6'd41: v = 32'ha81a664b;
            6'd42: v = 32'hc24b8b70; 6'd43: v = 32'hc76c51a3;
            6'd44: v = 32'hd192e819; 6'd45: v = 32'hd6990624;
            6'd46: v = 32'hf40e3585; 6'd47: v = 32'h106aa070;
            6'd48: v = 32'h19a4c116; 6'd49: v = 32'h1e376c08;
            6'd50: v = 32'h2748774c; 6'd51: v = 32'h34b0bcb5;
            6'd52: v = 32'h391c0cb3; 6'd53: v = 32'h4ed8aa4a;
            6'd54: v = 32'h5b9cca4f; 6'd55: v = 32'h682e6ff3;
            6'd56: v = 32'h748f82ee; 6'd57: v = 32'h78a5636f;
            6'd58: v = 32'h84c87814; 6'd59: v = 32'h8cc70208;
            6'd60: v = 32'h90befffa; 6'd61: v = 32'ha4506ceb;
            6'd62: v = 32'hbef9a3f7; 6'd63: v = 32'hc67178f2;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

endpackage

[sv/shs_front.sv]
// ----------------------------------------------------------------------------
// shs_front
// packs message bytes into big-endian words and generates the padding words
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module shs_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_kind,
    input  logic [7:0]         i_byte,
    output logic               o_push,
    output shs_pkg::t_word_item o_item,
    input  logic               i_room
);
    import shs_pkg::*;

    t_front_state r_state, n_state;
    logic [23:0]  r_acc;
    logic [5:0]   r_fill;
    logic [60:0]  r_bytes;
    logic [63:0]  w_bits;
    logic [31:0]  w_pad;
    logic         w_take;
    logic [3:0]   w_wi_next;

    assign w_take    = i_valid && o_ready;
    assign w_bits    = {r_bytes, 3'b000};
    assign w_wi_next = r_fill[5:2] + 4'd1;

    // pad word: held bytes, then the marker byte, then zeros
    always_comb begin
        case (r_fill[1:0])
            2'd0:    w_pad = {PadByte, 24'h0};
            2'd1:    w_pad = {r_acc[7:0], PadByte, 16'h0};
            2'd2:    w_pad = {r_acc[15:0], PadByte, 8'h0};
            default: w_pad = {r_acc[23:0], PadByte};
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE:   if (w_take && i_kind) n_state = F_PAD;
            F_PAD:    if (i_room) n_state = (w_wi_next == LenHiWord) ? F_LEN_HI : F_ZERO;
            F_ZERO:   if (i_room && w_wi_next == LenHiWord) n_state = F_LEN_HI;
            F_LEN_HI: if (i_room) n_state = F_LEN_LO;
            F_LEN_LO: if (i_room) n_state = F_IDLE;
            default:  n_state = F_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_ready     = 1'b0;
        o_push      = 1'b0;
        o_item.fin  = 1'b0;
        o_item.word = {r_acc, i_byte};
        case (r_state)
            F_IDLE: begin
                o_ready = i_room;
                o_push  = w_take && !i_kind && (r_fill[1:0] == 2'd3);
            end
            F_PAD: begin
                o_push      = i_room;
                o_item.word = w_pad;
            end
            F_ZERO: begin
                o_push      = i_room;
                o_item.word = 32'h0;
            end
            F_LEN_HI: begin
                o_push      = i_room;
                o_item.word = w_bits[63:32];
            end
            F_LEN_LO: begin
                o_push      = i_room;
                o_item.fin  = 1'b1;
                o_item.word = w_bits[31:0];
            end
            default: o_ready = 1'b0;
        endcase
    end

    // counters and byte accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_fill  <= 6'd0;
            r_bytes <= 61'd0;
        end else begin
            r_state <= n_state;
            if (r_state == F_IDLE && w_take && !i_kind) begin
                r_fill  <= r_fill + 6'd1;
                r_bytes <= r_bytes + 61'd1;
            end else if (r_state == F_LEN_LO && i_room) begin
                r_fill  <= 6'd0;
                r_bytes <= 61'd0;
            end else if (r_state != F_IDLE && i_room) begin
                r_fill <= {w_wi_next, 2'b00};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && w_take && !i_kind) begin
            r_acc <= {r_acc[15:0], i_byte};
        end
    end

endmodule

[sv/shs_queue.sv]
// ----------------------------------------------------------------------------
// shs_queue
// four-entry word queue between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module shs_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  shs_pkg::t_word_item i_item,
    output logic                o_room,
    input  logic                i_pop,
    output logic                o_avail,
    output shs_pkg::t_word_item o_item
);
    import shs_pkg::*;

    t_word_item r_mem [4];
    logic [1:0] r_wr;
    logic [1:0] r_rd;
    logic [2:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_room  = (r_cnt != 3'd4);
    assign o_avail = (r_cnt != 3'd0);
    assign o_item  = r_mem[r_rd];
    assign w_push  = i_push && o_room;
    assign w_pop   = i_pop && o_avail;

    // pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 2'd0;
            r_rd  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            if (w_push) r_wr <= r_wr + 2'd1;
            if (w_pop)  r_rd <= r_rd + 2'd1;
            r_cnt <= r_cnt + {2'b00, w_push} - {2'b00, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr] <= i_item;
    end

endmodule

[sv/shs_back.sv]
// ----------------------------------------------------------------------------
// shs_back
// gathers sixteen words, runs one compression round per cycle, emits digest
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module shs_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_avail,
    input  shs_pkg::t_word_item i_item,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [31:0]         o_word,
    output logic [2:0]          o_index,
    output logic                o_last
);
    import shs_pkg::*;

    t_back_state r_state, n_state;
    logic [31:0] r_w [BlockWords];
    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic [3:0]  r_cnt;
    logic [5:0]  r_round;
    logic [2:0]  r_idx;
    logic        r_fin;
    logic        w_take;
    logic        w_out;
    logic [31:0] w_wnew;
    logic [31:0] w_t1;
    logic [31:0] w_t2;
    logic [31:0] w_ch;
    logic [31:0] w_maj;

    assign w_take = o_pop && i_avail;
    assign w_out  = o_valid && i_ready;

    // round datapath
    assign w_wnew = ssig1(r_w[14]) + r_w[9] + ssig0(r_w[1]) + r_w[0];
    assign w_ch   = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign w_maj  = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign w_t1   = r_v[7] + bsig1(r_v[4]) + w_ch + round_k(r_round) + r_w[0];
    assign w_t2   = bsig0(r_v[0]) + w_maj;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_COLLECT: if (w_take && r_cnt == 4'd15) n_state = B_ROUND;
            B_ROUND:   if (r_round == 6'(Rounds - 1)) n_state = B_ADD;
            B_ADD:     n_state = r_fin ? B_EMIT : B_COLLECT;
            B_EMIT:    if (w_out && r_idx == 3'd7) n_state = B_COLLECT;
            default:   n_state = B_COLLECT;
        endcase
    end

    // outputs
    always_comb begin
        o_pop   = 1'b0;
        o_valid = 1'b0;
        case (r_state)
            B_COLLECT: o_pop = 1'b1;
            B_EMIT:    o_valid = 1'b1;
            default:   o_pop = 1'b0;
        endcase
    end

    assign o_word  = r_h[r_idx];
    assign o_index = r_idx;
    assign o_last  = (r_idx == 3'd7);

    // control registers and chaining words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_COLLECT;
            r_cnt   <= 4'd0;
            r_round <= 6'd0;
            r_idx   <= 3'd0;
            r_fin   <= 1'b0;
            for (int i = 0; i < 8; i++) r_h[i] <= init_h(3'(i));
        end else begin
            r_state <= n_state;
            case (r_state)
                B_COLLECT: begin
                    if (w_take) begin
                        r_cnt <= r_cnt + 4'd1;
                        if (r_cnt == 4'd15) begin
                            r_fin   <= i_item.fin;
                            r_round <= 6'd0;
                        end
                    end
                end
                B_ROUND: r_round <= r_round + 6'd1;
                B_ADD: begin
                    for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                    r_idx <= 3'd0;
                end
                B_EMIT: begin
                    if (w_out) begin
                        r_idx <= r_idx + 3'd1;
                        if (r_idx == 3'd7) begin
                            for (int i = 0; i < 8; i++) r_h[i] <= init_h(3'(i));
                        end
                    end
                end
                default: r_cnt <= 4'd0;
            endcase
        end
    end

    // schedule window and working variables
    always_ff @(posedge i_clk) begin
        if (r_state == B_COLLECT && w_take) begin
            for (int i = 0; i < BlockWords - 1; i++) r_w[i] <= r_w[i + 1];
            r_w[BlockWords - 1] <= i_item.word;
            if (r_cnt == 4'd15) begin
                for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
            end
        end else if (r_state == B_ROUND) begin
            for (int i = 0; i < BlockWords - 1; i++) r_w[i] <= r_w[i + 1];
            r_w[BlockWords - 1] <= w_wnew;
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + w_t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= w_t1 + w_t2;
        end
    end

endmodule

[sv/sha256_stream_hasher_unit.sv]
// ----------------------------------------------------------------------------
// sha256_stream_hasher_unit
// sha-256 over a byte stream with a word-stream digest output
// ----------------------------------------------------------------------------
// usage: each input word carries one message byte (tuser low) or a finish
// request (tuser high, tdata ignored). bytes are packed into 32-bit words by
// the front end and pass a four-entry queue to the compression engine.
// a 64-byte block is collected as 16 words, then compressed in 64 rounds and
// one add step; as the queue holds only four words, the input stalls during
// compression once the queue is full. bytes are taken at one per cycle while
// no finish is being padded and the queue has room.
// a finish generates 3 to 18 padding words, then one or two blocks,
// then eight digest words, index 0 first, the last with tlast. the front end
// takes the next message while the digest waits; a stalled receiver stops
// only the compression engine and, once the queue fills, the input.
// reset clears all counters and loads the initial hash values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module sha256_stream_hasher_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tuser,   // [0] kind
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // [31:0] digest_word, [34:32] word_index
    output logic        o_m_axis_tlast
);
    import shs_pkg::*;

    logic        w_push;
    logic        w_room;
    logic        w_pop;
    logic        w_avail;
    t_word_item  w_in_item;
    t_word_item  w_out_item;
    logic [31:0] w_word;
    logic [2:0]  w_index;

    // byte packing and padding
    shs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_kind  (i_s_axis_tuser),
        .i_byte  (i_s_axis_tdata),
        .o_push  (w_push),
        .o_item  (w_in_item),
        .i_room  (w_room)
    );

    // word queue
    shs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_in_item),
        .o_room  (w_room),
        .i_pop   (w_pop),
        .o_avail (w_avail),
        .o_item  (w_out_item)
    );

    // compression and digest output
    shs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (w_avail),
        .i_item  (w_out_item),
        .o_pop   (w_pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_word  (w_word),
        .o_index (w_index),
        .o_last  (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {5'b00000, w_index, w_word};

endmodule

[sv/shs_checker.sv]
// ----------------------------------------------------------------------------
// shs_checker
// port-level checks on the digest output of the hasher
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sha256_stream_hasher_unit_defines.svh"
module shs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [39:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast
);
    // stalled word holds
    `SHS_CHECK_NEXT(a_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata), "digest word changed under stall")
    // tlast marks index seven only
    `SHS_CHECK_NOW(a_last, o_m_axis_tvalid, o_m_axis_tlast == (o_m_axis_tdata[34:32] == 3'd7), "tlast does not match word index")
    // words of one digest come in order
    `SHS_CHECK_NEXT(a_order, o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast, o_m_axis_tvalid && o_m_axis_tdata[34:32] == $past(o_m_axis_tdata[34:32]) + 3'd1, "digest word skipped")
    // tvalid drops once the last digest word is taken
    `SHS_CHECK_NEXT(a_gap, o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tlast, !o_m_axis_tvalid, "digest follows digest with no block")
endmodule

bind sha256_stream_hasher_unit shs_checker u_shs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
